>>> rtl/mck_pkg.sv
// Shared types, element lengths and the character code table of the Morse keyer.
package mck_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [3:0] LEN_DOT      = 4'd1;
  localparam logic [3:0] LEN_DASH     = 4'd3;
  localparam logic [3:0] LEN_GAP      = 4'd1;
  localparam logic [3:0] LEN_CHAR_GAP = 4'd3;
  localparam logic [3:0] LEN_SPACE    = 4'd12;

  // One keyed character: marks left-aligned in pat, bit 5 first, 1 = dash.
  typedef struct packed {
    logic       space;
    logic [2:0] marks;
    logic [5:0] pat;
  } entry_t;

  typedef struct packed {
    logic   known;
    entry_t entry;
  } class_t;

  function automatic class_t classify(input logic [7:0] char_code);
    logic [7:0] c;
    class_t     r;
    c = char_code;
    r = '0;
    r.known = 1'b1;
    // fold lower case letters onto upper case
    if (c >= 8'h61 && c <= 8'h7a) c = c - 8'd32;
    unique case (c)
      8'h20: r.entry.space = 1'b1;
      8'h41: r.entry = '{1'b0, 3'd2, 6'b010000}; // A
      8'h42: r.entry = '{1'b0, 3'd4, 6'b100000}; // B
      8'h43: r.entry = '{1'b0, 3'd4, 6'b101000}; // C
      8'h44: r.entry = '{1'b0, 3'd3, 6'b100000}; // D
      8'h45: r.entry = '{1'b0, 3'd1, 6'b000000}; // E
      8'h46: r.entry = '{1'b0, 3'd4, 6'b001000}; // F
      8'h47: r.entry = '{1'b0, 3'd3, 6'b110000}; // G
      8'h48: r.entry = '{1'b0, 3'd4, 6'b000000}; // H
      8'h49: r.entry = '{1'b0, 3'd2, 6'b000000}; // I
      8'h4a: r.entry = '{1'b0, 3'd4, 6'b011100}; // J
      8'h4b: r.entry = '{1'b0, 3'd3, 6'b101000}; // K
      8'h4c: r.entry = '{1'b0, 3'd4, 6'b010000}; // L
      8'h4d: r.entry = '{1'b0, 3'd2, 6'b110000}; // M
      8'h4e: r.entry = '{1'b0, 3'd2, 6'b100000}; // N
      8'h4f: r.entry = '{1'b0, 3'd3, 6'b111000}; // O
      8'h50: r.entry = '{1'b0, 3'd4, 6'b011000}; // P
      8'h51: r.entry = '{1'b0, 3'd4, 6'b110100}; // Q
      8'h52: r.entry = '{1'b0, 3'd3, 6'b010000}; // R
      8'h53: r.entry = '{1'b0, 3'd3, 6'b000000}; // S
      8'h54: r.entry = '{1'b0, 3'd1, 6'b100000}; // T
      8'h55: r.entry = '{1'b0, 3'd3, 6'b001000}; // U
      8'h56: r.entry = '{1'b0, 3'd4, 6'b000100}; // V
      8'h57: r.entry = '{1'b0, 3'd3, 6'b011000}; // W
      8'h58: r.entry = '{1'b0, 3'd4, 6'b100100}; // X
      8'h59: r.entry = '{1'b0, 3'd4, 6'b101100}; // Y
      8'h5a: r.entry = '{1'b0, 3'd4, 6'b110000}; // Z
      8'h30: r.entry = '{1'b0, 3'd5, 6'b111110}; // 0
      8'h31: r.entry = '{1'b0, 3'd5, 6'b011110}; // 1
      8'h32: r.entry = '{1'b0, 3'd5, 6'b001110}; // 2
      8'h33: r.entry = '{1'b0, 3'd5, 6'b000110}; // 3
      8'h34: r.entry = '{1'b0, 3'd5, 6'b000010}; // 4
      8'h35: r.entry = '{1'b0, 3'd5, 6'b000000}; // 5
      8'h36: r.entry = '{1'b0, 3'd5, 6'b100000}; // 6
      8'h37: r.entry = '{1'b0, 3'd5, 6'b110000}; // 7
      8'h38: r.entry = '{1'b0, 3'd5, 6'b111000}; // 8
      8'h39: r.entry = '{1'b0, 3'd5, 6'b111100}; // 9
      8'ha4, 8'ha5: r.entry = '{1'b0, 3'd5, 6'b110110}; // n tilde
      8'h2e: r.entry = '{1'b0, 3'd6, 6'b010101}; // period
      8'h2c: r.entry = '{1'b0, 3'd6, 6'b110011}; // comma
      8'h3f: r.entry = '{1'b0, 3'd6, 6'b001100}; // question mark
      8'h21: r.entry = '{1'b0, 3'd6, 6'b101011}; // exclamation
      8'h22: r.entry = '{1'b0, 3'd6, 6'b010010}; // double quote
      default: r.known = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/morse_char_keyer_top.sv
// Top level of the Morse character keyer: front end, queue and element sequencer.
//
// Input channel (in_valid / in_stall / in_char_code): one character byte per
// transfer. Letters of either case, digits, n tilde (164, 165), . , ? ! " and
// space are keyed; any other byte is taken and produces nothing.
// Output channel (out_valid / out_stall / out_*): one element per transfer,
// tone or silence with a length in dot units; out_last marks the final element
// of a character. A character with n marks gives 2n elements, a space one.
// Throughput: while characters are queued and out_stall is low, the sequencer
// issues one element per cycle; input transfers are accepted while the queue
// has room.
// When the sequencer is idle, a transfer passes through the queue, the
// sequencer registers and the output register before its first element appears.
// Reset empties the queue, idles the sequencer and clears out_valid.
// When out_stall is high while out_valid is set the output register holds; the
// queue then fills and in_stall rises once it is full.
module morse_char_keyer_top #(
  parameter int unsigned QUEUE_DEPTH = mck_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_tone_on,
  output logic [3:0] out_length_units,
  output logic       out_last
);
  import mck_pkg::*;

  logic   q_full, q_empty, push, pop;
  entry_t push_entry, q_head;

  mck_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  mck_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  mck_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tone_on      (out_tone_on),
    .out_length_units (out_length_units),
    .out_last         (out_last)
  );

endmodule

>>> rtl/mck_front.sv
// Front end: takes character transfers, classifies them and pushes known ones to the queue.
module mck_front (
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_char_code,
  input  logic            q_full,
  output logic            push,
  output mck_pkg::entry_t push_entry
);
  import mck_pkg::*;

  class_t cls;

  always_comb begin
    cls        = classify(in_char_code);
    in_stall   = q_full;
    // drop unknown bytes: accept them but push nothing
    push       = in_valid && !q_full && cls.known;
    push_entry = cls.entry;
  end

endmodule

>>> rtl/mck_queue.sv
// Short queue of classified characters between the front end and the sequencer.
module mck_queue #(
  parameter int unsigned DEPTH = mck_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mck_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output mck_pkg::entry_t head
);
  import mck_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  always_comb begin
    full       = (cnt_r == CNT_FULL);
    empty      = (cnt_r == '0);
    head       = mem_r[rd_ptr_r];
    do_push    = push && !full;
    do_pop     = pop && !empty;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule

>>> rtl/mck_back.sv
// Back end: steps through the marks of one character and drives the element output register.
module mck_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  mck_pkg::entry_t q_head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_tone_on,
  output logic [3:0]      out_length_units,
  output logic            out_last
);
  import mck_pkg::*;

  logic       busy_r, busy_nxt;
  logic       phase_r, phase_nxt;   // 0: mark, 1: gap after mark
  logic       space_r, space_nxt;
  logic [2:0] left_r, left_nxt;
  logic [5:0] pat_r, pat_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       tone_r, tone_nxt;
  logic [3:0] len_r, len_nxt;
  logic       last_r, last_nxt;

  logic       out_load;
  logic       e_tone, e_last;
  logic [3:0] e_len;

  always_comb begin
    // current element
    if (space_r) begin
      e_tone = 1'b0;
      e_len  = LEN_SPACE;
      e_last = 1'b1;
    end else if (!phase_r) begin
      e_tone = 1'b1;
      e_len  = pat_r[5] ? LEN_DASH : LEN_DOT;
      e_last = 1'b0;
    end else begin
      e_tone = 1'b0;
      e_last = (left_r == 3'd1);
      e_len  = e_last ? LEN_CHAR_GAP : LEN_GAP;
    end

    out_load      = !out_valid_r || !out_stall;
    pop           = !q_empty && (!busy_r || (out_load && e_last));

    busy_nxt      = busy_r;
    phase_nxt     = phase_r;
    space_nxt     = space_r;
    left_nxt      = left_r;
    pat_nxt       = pat_r;
    out_valid_nxt = out_valid_r;
    tone_nxt      = tone_r;
    len_nxt       = len_r;
    last_nxt      = last_r;

    if (out_load) begin
      out_valid_nxt = busy_r;
      tone_nxt      = e_tone;
      len_nxt       = e_len;
      last_nxt      = e_last;
      if (busy_r) begin
        // advance: mark to gap, gap to next mark
        if (!phase_r) begin
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          pat_nxt   = {pat_r[4:0], 1'b0};
          left_nxt  = left_r - 1'b1;
        end
        if (e_last) busy_nxt = 1'b0;
      end
    end

    if (pop) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      space_nxt = q_head.space;
      left_nxt  = q_head.marks;
      pat_nxt   = q_head.pat;
    end

    out_valid        = out_valid_r;
    out_tone_on      = tone_r;
    out_length_units = len_r;
    out_last         = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    space_r <= space_nxt;
    left_r  <= left_nxt;
    pat_r   <= pat_nxt;
    tone_r  <= tone_nxt;
    len_r   <= len_nxt;
    last_r  <= last_nxt;
  end

endmodule

>>> tb/sv/tb_morse_char_keyer_top.sv
// Self-checking testbench for the Morse character keyer top level.
`timescale 1ns / 1ps

module tb_morse_char_keyer_top;
  import mck_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic       tone;
    logic [3:0] len;
    logic       last;
  } element_t;

  // Expected Morse elements for each character transfer, checked in order.
  class keying_board;
    element_t due_q[$];
    int       errors;

    function string pattern_of(input logic [7:0] code, output bit known);
      logic [7:0] c;
      string      p;
      c = code;
      p = "";
      known = 1'b1;
      if (c >= "a" && c <= "z") c = c - 8'd32;
      case (c)
        "A": p = ".-";     "B": p = "-...";   "C": p = "-.-.";   "D": p = "-..";
        "E": p = ".";      "F": p = "..-.";   "G": p = "--.";    "H": p = "....";
        "I": p = "..";     "J": p = ".---";   "K": p = "-.-";    "L": p = ".-..";
        "M": p = "--";     "N": p = "-.";     "O": p = "---";    "P": p = ".--.";
        "Q": p = "--.-";   "R": p = ".-.";    "S": p = "...";    "T": p = "-";
        "U": p = "..-";    "V": p = "...-";   "W": p = ".--";    "X": p = "-..-";
        "Y": p = "-.--";   "Z": p = "--..";
        "0": p = "-----";  "1": p = ".----";  "2": p = "..---";  "3": p = "...--";
        "4": p = "....-";  "5": p = ".....";  "6": p = "-....";  "7": p = "--...";
        "8": p = "---..";  "9": p = "----.";
        8'ha4, 8'ha5: p = "--.--";
        ".": p = ".-.-.-";
        ",": p = "--..--";
        "?": p = "..--..";
        "!": p = "-.-.--";
        "\"": p = ".-..-.";
        default: known = 1'b0;
      endcase
      return p;
    endfunction

    function void note_char(input logic [7:0] code);
      string    p;
      bit       known;
      element_t e;
      if (code == " ") begin
        e = '{1'b0, LEN_SPACE, 1'b1};
        due_q.push_back(e);
        return;
      end
      p = pattern_of(code, known);
      if (!known) return;
      for (int i = 0; i < p.len(); i++) begin
        e = '{1'b1, (p[i] == "-") ? LEN_DASH : LEN_DOT, 1'b0};
        due_q.push_back(e);
        if (i == p.len() - 1) e = '{1'b0, LEN_CHAR_GAP, 1'b1};
        else e = '{1'b0, LEN_GAP, 1'b0};
        due_q.push_back(e);
      end
    endfunction

    function void check_elem(input logic tone, input logic [3:0] len, input logic last);
      element_t e;
      if (due_q.size() == 0) begin
        $error("unexpected element: tone_on=%0d length_units=%0d last=%0d", tone, len, last);
        errors++;
        return;
      end
      e = due_q.pop_front();
      if (tone !== e.tone) begin
        $error("tone_on: expected %0d, got %0d", e.tone, tone);
        errors++;
      end
      if (len !== e.len) begin
        $error("length_units: expected %0d, got %0d", e.len, len);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_code;
  logic       out_valid;
  logic       out_stall;
  logic       out_tone_on;
  logic [3:0] out_length_units;
  logic       out_last;

  keying_board sb = new();

  int snd_idle_pct;
  int rcv_idle_pct;
  bit hold_go;
  int stale_cycles;

  string keyable = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789.,?!\" ";

  morse_char_keyer_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tone_on      (out_tone_on),
    .out_length_units (out_length_units),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stall, plus one long hold-off once requested.
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && hold_cnt < HOLD_CYCLES) begin
        out_stall <= 1'b1;
        hold_cnt++;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_char(in_char_code);
      if (out_valid && !out_stall) sb.check_elem(out_tone_on, out_length_units, out_last);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stale_cycles <= 0;
    else stale_cycles <= stale_cycles + 1;
    if (stale_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one character and hold it until the transfer; call at a falling edge.
  task automatic send_char(input logic [7:0] code);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected element has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 8'($urandom_range(255));
    r = $urandom_range(keyable.len() + 1);
    if (r == keyable.len()) return 8'ha4;
    if (r == keyable.len() + 1) return 8'ha5;
    return keyable[r];
  endfunction

  task automatic run_random(input int snd_pct, input int rcv_pct, input int count);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    repeat (count) send_char(pick_char());
    drain();
  endtask

  initial begin
    logic [7:0] directed[$];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_code = 8'h00;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_go = 1'b0;
    stale_cycles = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // field extremes, case folding, digits incl. one, all marks, n tilde, space, junk
    directed = '{8'h00, 8'hff, "A", "z", "E", "T", "0", "1", "5", "9", ",", "!",
                 ".", "?", "\"", " ", 8'ha4, 8'ha5, "m", 8'h7f, 8'h60, 8'h5b, "@"};
    foreach (directed[i]) send_char(directed[i]);
    drain();

    run_random(27, 88, 140);
    run_random(88, 27, 140);

    // fill the block while the receiver holds off
    hold_go = 1'b1;
    run_random(0, 0, 140);

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/mck_pkg.sv
rtl/mck_front.sv
rtl/mck_queue.sv
rtl/mck_back.sv
rtl/morse_char_keyer_top.sv
tb/sv/tb_morse_char_keyer_top.sv
